FILE: design/llt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types and constants of the laser line triangulation core.
// ----------------------------------------------------------------------------
package llt_pkg;

   localparam int unsigned PIX_W       = 8;
   localparam int unsigned COL_W       = 12;
   localparam int unsigned DIM_W       = 13;
   localparam int unsigned FIX_W       = 32;
   localparam int unsigned PHYS_W      = 31;
   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned MAX_DIM     = 4096;
   localparam int unsigned DIV_W       = 64;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned ADDR_W      = 5;
   localparam logic [PIX_W-1:0] HIT_LEVEL = 8'd255;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH    = 3'd0,
      REG_IMAGE_HEIGHT   = 3'd1,
      REG_COT_ANGLE      = 3'd2,
      REG_BASELINE       = 3'd3,
      REG_FOCAL_DISTANCE = 3'd4,
      REG_SENSOR_WIDTH   = 3'd5,
      REG_SENSOR_HEIGHT  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]        image_width;
      logic [DIM_W-1:0]        image_height;
      logic signed [FIX_W-1:0] cot_angle;
      logic [PHYS_W-1:0]       baseline;
      logic [PHYS_W-1:0]       focal_distance;
      logic [PHYS_W-1:0]       sensor_width;
      logic [PHYS_W-1:0]       sensor_height;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [COL_W-1:0] row;
   } hit_type;

   typedef struct packed {
      logic idle;
      logic finishing;
   } back_stat_type;

endpackage
`default_nettype wire

FILE: design/llt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llt_front
// Accept pixels, keep laser hits in a short queue, drop all others.
// ----------------------------------------------------------------------------
module llt_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   output logic                          full,
   input  wire logic [llt_pkg::PIX_W-1:0] pixel,
   input  wire logic [llt_pkg::COL_W-1:0] column,
   input  wire logic [llt_pkg::COL_W-1:0] row,
   input  wire logic                     q_pop,
   output logic                          q_valid,
   output llt_pkg::hit_type              q_entry
);
   import llt_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   hit_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               hit_push;
   logic               do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_entry  = mem_ff[rd_ptr_ff];
   assign hit_push = push && !full && (pixel == HIT_LEVEL);
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = hit_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(hit_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_push) begin
         mem_ff[wr_ptr_ff] <= '{column: column, row: row};
      end
   end

endmodule
`default_nettype wire

FILE: design/llt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module llt_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire logic [llt_pkg::DIV_W-1:0] num,
   input  wire logic [llt_pkg::DIV_W-1:0] den,
   output logic                           done,
   output logic [llt_pkg::DIV_W-1:0]      quo
);
   import llt_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W+1:0] trial;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (go) begin
         cnt_in = CNT_W'(DIV_W);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         if (!trial[DIV_W+1]) begin
            rem_in = trial[DIV_W:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule
`default_nettype wire

FILE: design/llt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llt_back
// Turn one queued hit into a 3D point through a shared divider.
// ----------------------------------------------------------------------------
module llt_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire llt_pkg::cfg_type           cfg,
   input  wire logic                       q_valid,
   input  wire llt_pkg::hit_type           q_entry,
   output logic                            q_pop,
   output llt_pkg::back_stat_type          stat,
   output logic                            empty,
   input  wire logic                       pop,
   output logic [llt_pkg::COL_W-1:0]       hit_row,
   output logic signed [llt_pkg::FIX_W-1:0] point_x,
   output logic signed [llt_pkg::FIX_W-1:0] point_y,
   output logic signed [llt_pkg::FIX_W-1:0] point_z,
   output logic                            saturated
);
   import llt_pkg::*;

   localparam int unsigned PROD_W = PHYS_W + COL_W;
   localparam logic signed [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_PROD   = 15'b000000000000010,
      ST_DIV_W  = 15'b000000000000100,
      ST_DIV_H  = 15'b000000000001000,
      ST_FORM   = 15'b000000000010000,
      ST_DIV_Q  = 15'b000000000100000,
      ST_DEN    = 15'b000000001000000,
      ST_DIV_Z  = 15'b000000010000000,
      ST_MUL_Y  = 15'b000000100000000,
      ST_SEND_Y = 15'b000001000000000,
      ST_DIV_Y  = 15'b000010000000000,
      ST_MUL_X  = 15'b000100000000000,
      ST_SEND_X = 15'b001000000000000,
      ST_DIV_X  = 15'b010000000000000,
      ST_DONE   = 15'b100000000000000
   } state_type;

   function automatic logic signed [FIX_W-1:0] clamp32(input logic signed [DIV_W-1:0] v);
      logic signed [DIV_W-1:0] hi;
      logic signed [DIV_W-1:0] lo;
      hi = DIV_W'(FIX_MAX);
      lo = -hi - 64'sd1;
      if (v > hi) return FIX_MAX;
      if (v < lo) return -FIX_MAX - 32'sd1;
      return v[FIX_W-1:0];
   endfunction

   function automatic logic clips(input logic signed [DIV_W-1:0] v);
      return (v != DIV_W'(signed'(clamp32(v))));
   endfunction

   function automatic logic [DIV_W-1:0] mag(input logic signed [DIV_W-1:0] v);
      return v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
   endfunction

   state_type                 state_ff, state_in;
   logic [COL_W-1:0]          col_ff, col_in, row_ff, row_in;
   logic [PROD_W-1:0]         prh_ff, prh_in, sw_ff, sw_in, sh_ff, sh_in;
   logic signed [FIX_W-1:0]   s_ff, s_in, v_ff, v_in;
   logic signed [FIX_W-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [DIV_W-1:0]   den_ff, den_in, prod_ff, prod_in;
   logic                      neg_ff, neg_in, flag_ff, flag_in;
   logic                      go_ff, go_in;
   logic [DIV_W-1:0]          num_ff, num_in, dvs_ff, dvs_in;
   logic                      out_valid_ff, out_valid_in;
   logic [COL_W-1:0]          o_row_ff, o_row_in;
   logic signed [FIX_W-1:0]   o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in;
   logic                      o_sat_ff, o_sat_in;
   logic                      div_done;
   logic [DIV_W-1:0]          div_quo;
   logic signed [DIV_W-1:0]   sq_quo;
   logic signed [DIV_W-1:0]   s_raw, v_raw;
   logic                      zero_cfg;

   llt_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .num   (num_ff),
      .den   (dvs_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign empty     = !out_valid_ff;
   assign hit_row   = o_row_ff;
   assign point_x   = o_x_ff;
   assign point_y   = o_y_ff;
   assign point_z   = o_z_ff;
   assign saturated = o_sat_ff;
   assign stat      = '{idle: (state_ff == ST_IDLE), finishing: (state_ff == ST_DONE)};
   assign zero_cfg  = (cfg.image_width == '0) || (cfg.image_height == '0) ||
                      (cfg.focal_distance == '0);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      prh_in       = prh_ff;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      s_in         = s_ff;
      v_in         = v_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      flag_in      = flag_ff;
      go_in        = 1'b0;
      num_in       = num_ff;
      dvs_in       = dvs_ff;
      out_valid_in = out_valid_ff && !pop;
      o_row_in     = o_row_ff;
      o_x_in       = o_x_ff;
      o_y_in       = o_y_ff;
      o_z_in       = o_z_ff;
      o_sat_in     = o_sat_ff;
      q_pop        = 1'b0;
      sq_quo       = neg_ff ? -signed'(div_quo) : signed'(div_quo);
      s_raw        = signed'(DIV_W'(sw_ff)) + signed'(DIV_W'(cfg.baseline >> 1))
                   - signed'(DIV_W'(cfg.sensor_width >> 1));
      v_raw        = signed'(DIV_W'(sh_ff)) - signed'(DIV_W'(cfg.sensor_height >> 1));
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               col_in  = q_entry.column;
               row_in  = q_entry.row;
               flag_in = 1'b0;
               if (zero_cfg) begin
                  px_in    = FIX_MAX;
                  py_in    = FIX_MAX;
                  pz_in    = FIX_MAX;
                  flag_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            go_in    = 1'b1;
            num_in   = DIV_W'(PROD_W'(cfg.sensor_width) * PROD_W'(col_ff));
            dvs_in   = DIV_W'(cfg.image_width);
            prh_in   = PROD_W'(cfg.sensor_height) * PROD_W'(row_ff);
            state_in = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (div_done) begin
               sw_in    = div_quo[PROD_W-1:0];
               go_in    = 1'b1;
               num_in   = DIV_W'(prh_ff);
               dvs_in   = DIV_W'(cfg.image_height);
               state_in = ST_DIV_H;
            end
         end
         ST_DIV_H: begin
            if (div_done) begin
               sh_in    = div_quo[PROD_W-1:0];
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            s_in     = clamp32(s_raw);
            v_in     = clamp32(v_raw);
            flag_in  = flag_ff || clips(s_raw) || clips(v_raw);
            neg_in   = s_raw[DIV_W-1];
            go_in    = 1'b1;
            num_in   = mag(DIV_W'(signed'(clamp32(s_raw)))) << FRAC_BITS;
            dvs_in   = DIV_W'(cfg.focal_distance);
            state_in = ST_DIV_Q;
         end
         ST_DIV_Q: begin
            if (div_done) begin
               den_in   = sq_quo + DIV_W'(cfg.cot_angle);
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            if (den_ff == '0) begin
               pz_in    = FIX_MAX;
               flag_in  = 1'b1;
               state_in = ST_MUL_Y;
            end else begin
               go_in    = 1'b1;
               num_in   = DIV_W'(cfg.baseline) << FRAC_BITS;
               dvs_in   = mag(den_ff);
               neg_in   = den_ff[DIV_W-1];
               state_in = ST_DIV_Z;
            end
         end
         ST_DIV_Z: begin
            if (div_done) begin
               pz_in    = clamp32(sq_quo);
               flag_in  = flag_ff || clips(sq_quo);
               state_in = ST_MUL_Y;
            end
         end
         ST_MUL_Y: begin
            prod_in  = pz_ff * v_ff;
            state_in = ST_SEND_Y;
         end
         ST_SEND_Y: begin
            go_in    = 1'b1;
            num_in   = mag(prod_ff);
            dvs_in   = DIV_W'(cfg.focal_distance);
            neg_in   = prod_ff[DIV_W-1];
            state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            if (div_done) begin
               py_in    = clamp32(sq_quo);
               flag_in  = flag_ff || clips(sq_quo);
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            prod_in  = pz_ff * s_ff;
            state_in = ST_SEND_X;
         end
         ST_SEND_X: begin
            go_in    = 1'b1;
            num_in   = mag(prod_ff);
            dvs_in   = DIV_W'(cfg.focal_distance);
            neg_in   = prod_ff[DIV_W-1];
            state_in = ST_DIV_X;
         end
         ST_DIV_X: begin
            if (div_done) begin
               px_in    = clamp32(sq_quo);
               flag_in  = flag_ff || clips(sq_quo);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               o_row_in     = row_ff;
               o_x_in       = px_ff;
               o_y_in       = py_ff;
               o_z_in       = pz_ff;
               o_sat_in     = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      prh_ff   <= prh_in;
      sw_ff    <= sw_in;
      sh_ff    <= sh_in;
      s_ff     <= s_in;
      v_ff     <= v_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      den_ff   <= den_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      flag_ff  <= flag_in;
      num_ff   <= num_in;
      dvs_ff   <= dvs_in;
      o_row_ff <= o_row_in;
      o_x_ff   <= o_x_in;
      o_y_ff   <= o_y_in;
      o_z_ff   <= o_z_in;
      o_sat_ff <= o_sat_in;
   end

endmodule
`default_nettype wire

FILE: design/laser_line_triangulation_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laser_line_triangulation_core
// Laser line triangulation: camera pixels in, 3D points out.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle; the input stalls only when four hits wait
// in the queue. Pixels below full intensity are dropped at once; hits enter a
// four-entry queue and are turned into points by one 64-bit restoring divider
// that gives one quotient bit a cycle. A hit passes from the queue to the
// result register through six divisions and control states, five divisions
// when the depth denominator is zero and none when the width, height or focal
// distance is zero.
// ----------------------------------------------------------------------------
module laser_line_triangulation_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [llt_pkg::PIX_W-1:0]   req_pixel,
   input  wire logic [llt_pkg::COL_W-1:0]   req_column,
   input  wire logic [llt_pkg::COL_W-1:0]   req_row,
   output logic                             empty,
   input  wire logic                        pop,
   output logic [llt_pkg::COL_W-1:0]        rsp_hit_row,
   output logic signed [llt_pkg::FIX_W-1:0] rsp_point_x,
   output logic signed [llt_pkg::FIX_W-1:0] rsp_point_y,
   output logic signed [llt_pkg::FIX_W-1:0] rsp_point_z,
   output logic                             rsp_saturated,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [llt_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import llt_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           q_pop;
   logic           q_valid;
   hit_type        q_entry;
   back_stat_type  stat;
   logic           cfg_wr;
   logic [DIM_W-1:0] dim_val;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign dim_val = (pwdata[DIM_W-1:0] > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                         : pwdata[DIM_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (reg_index_type'(paddr[4:2]))
            REG_IMAGE_WIDTH:    cfg_in.image_width    = dim_val;
            REG_IMAGE_HEIGHT:   cfg_in.image_height   = dim_val;
            REG_COT_ANGLE:      cfg_in.cot_angle      = signed'(pwdata);
            REG_BASELINE:       cfg_in.baseline       = pwdata[PHYS_W-1:0];
            REG_FOCAL_DISTANCE: cfg_in.focal_distance = pwdata[PHYS_W-1:0];
            REG_SENSOR_WIDTH:   cfg_in.sensor_width   = pwdata[PHYS_W-1:0];
            REG_SENSOR_HEIGHT:  cfg_in.sensor_height  = pwdata[PHYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[4:2]))
         REG_IMAGE_WIDTH:    prdata = 32'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:   prdata = 32'(cfg_ff.image_height);
         REG_COT_ANGLE:      prdata = cfg_ff.cot_angle;
         REG_BASELINE:       prdata = 32'(cfg_ff.baseline);
         REG_FOCAL_DISTANCE: prdata = 32'(cfg_ff.focal_distance);
         REG_SENSOR_WIDTH:   prdata = 32'(cfg_ff.sensor_width);
         REG_SENSOR_HEIGHT:  prdata = 32'(cfg_ff.sensor_height);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width: DIM_W'(800), image_height: DIM_W'(600),
                    cot_angle: 32'sd9398, baseline: PHYS_W'(65536),
                    focal_distance: PHYS_W'(655360), sensor_width: PHYS_W'(262144),
                    sensor_height: PHYS_W'(196608)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   llt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .pixel   (req_pixel),
      .column  (req_column),
      .row     (req_row),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_entry (q_entry)
   );

   llt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .stat      (stat),
      .empty     (empty),
      .pop       (pop),
      .hit_row   (rsp_hit_row),
      .point_x   (rsp_point_x),
      .point_y   (rsp_point_y),
      .point_z   (rsp_point_z),
      .saturated (rsp_saturated)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && stat.idle)
      else $error("queue popped while empty or back end busy");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $fell(empty) |-> $past(stat.finishing))
      else $error("result appeared without a finished point");

   a_transfer_while_done: assert property (@(posedge clock) disable iff (reset)
      stat.finishing && empty |=> !empty)
      else $error("finished point not moved to result register");

endmodule
`default_nettype wire
